// ===== design/ktpr_pkg.sv =====
package ktpr_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Fixed field widths
    localparam int KEY_W   = 31;
    localparam int SCORE_W = 31;
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int STAT_W  = 3;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_REPLACED = 3'd3,
        ST_DROPPED  = 3'd4,
        ST_LOADED   = 3'd5
    } t_status;

    // Command broadcast to every cell in the execute cycle
    typedef struct packed {
        logic                exec;
        logic [MODE_W-1:0]   mode;
        logic [KEY_W-1:0]    key;
        logic [SCORE_W-1:0]  score;
        logic [SLOT_W-1:0]   load_slot;
    } t_cmd;

    // Priority chain passed from cell to cell, lowest slot first
    typedef struct packed {
        logic                hit;
        logic                cand;
        logic [IDX_W-1:0]    hit_idx;
        logic [IDX_W-1:0]    cand_idx;
        logic [SCORE_W-1:0]  hit_score;
    } t_chain;

endpackage

// ===== design/ktpr_if.sv =====
// Input item channel
interface ktpr_in_if;
    logic                           valid;
    logic                           ready;
    logic [ktpr_pkg::MODE_W-1:0]    mode;
    logic [ktpr_pkg::KEY_W-1:0]     book_key;
    logic [ktpr_pkg::SCORE_W-1:0]   score_in;
    logic [ktpr_pkg::SLOT_W-1:0]    load_slot;

    modport source (output valid, output mode, output book_key, output score_in,
                    output load_slot, input ready);
    modport sink   (input valid, input mode, input book_key, input score_in,
                    input load_slot, output ready);
endinterface

// Result channel
interface ktpr_out_if;
    logic                           valid;
    logic                           ready;
    logic [ktpr_pkg::STAT_W-1:0]    status;
    logic [ktpr_pkg::SCORE_W-1:0]   score_out;
    logic [ktpr_pkg::SLOT_W-1:0]    slot_index;

    modport source (output valid, output status, output score_out,
                    output slot_index, input ready);
    modport sink   (input valid, input status, input score_out,
                    input slot_index, output ready);
endinterface

// ===== design/ktpr_cell.sv =====
module ktpr_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ktpr_pkg::IDX_W-1:0]   i_id,
    input  logic                         i_act,
    input  ktpr_pkg::t_cmd               i_cmd,
    input  logic                         i_any_hit,
    input  ktpr_pkg::t_chain             i_chain,
    output ktpr_pkg::t_chain             o_chain,
    output logic                         o_wr
);

    logic [ktpr_pkg::KEY_W-1:0]   r_key;
    logic [ktpr_pkg::SCORE_W-1:0] r_score;
    logic                         r_valid;

    logic w_match;
    logic w_cand;
    logic w_hit_first;
    logic w_cand_first;
    logic w_upd;
    logic w_repl;
    logic w_load;

    // Local compares
    assign w_match = i_act && r_valid && (r_key == i_cmd.key);
    assign w_cand  = i_act && (!r_valid || (r_score <= i_cmd.score));

    // First match / first candidate along the chain
    assign w_hit_first  = w_match && !i_chain.hit;
    assign w_cand_first = w_cand && !i_chain.cand;

    always_comb begin
        o_chain           = i_chain;
        o_chain.hit       = i_chain.hit || w_match;
        o_chain.cand      = i_chain.cand || w_cand;
        if (w_hit_first) begin
            o_chain.hit_idx   = i_id;
            o_chain.hit_score = r_score;
        end
        if (w_cand_first) begin
            o_chain.cand_idx = i_id;
        end
    end

    // Write decisions
    assign w_upd  = i_cmd.exec && (i_cmd.mode == ktpr_pkg::MODE_ADD) && w_hit_first;
    assign w_repl = i_cmd.exec && (i_cmd.mode == ktpr_pkg::MODE_ADD) && !i_any_hit
                    && w_cand_first;
    assign w_load = i_cmd.exec && (i_cmd.mode == ktpr_pkg::MODE_LOAD)
                    && (32'(i_cmd.load_slot) == 32'(i_id));
    assign o_wr   = w_upd || w_repl || w_load;

    // Slot payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_repl || w_load) begin
            r_key <= i_cmd.key;
        end
        if (o_wr) begin
            r_score <= i_cmd.score;
        end
    end

    // Valid mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_repl || w_load) begin
            r_valid <= 1'b1;
        end
    end

endmodule

// ===== design/keyed_table_priority_replace_top.sv =====
// Keyed score table with priority replacement.
// Input channel i_in carries one operation per transfer: lookup, add/update
// or direct slot load. Output channel o_out returns exactly one result per
// operation, in order. The configuration port (i_cfg_we, i_cfg_wdata) sets
// the number of active slots; write it only while the block is idle.
// An accepted operation waits in the command register until it executes, and
// its result is then presented from the output register.
// Throughput: one operation per cycle unless the receiver stalls. The row of
// slot cells resolves the first matching key and the first replaceable slot
// through a priority chain that runs cell to cell within the execute cycle.
// Reset clears all valid marks and sets the active count to 16; keys and
// scores are not cleared. When the receiver stalls, the result is held in
// the output register; one more operation may be accepted and waits in the
// command register, after which i_in.ready drops until the result is taken.
module keyed_table_priority_replace_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ktpr_in_if.sink                          i_in,
    ktpr_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [ktpr_pkg::CFG_W-1:0]       i_cfg_wdata
);

    logic [ktpr_pkg::CFG_W-1:0]   r_cfg;
    logic [ktpr_pkg::CNT_W-1:0]   w_act_cnt;

    logic                         r_busy;
    logic                         n_busy;
    ktpr_pkg::t_cmd               r_cmd;
    ktpr_pkg::t_cmd               w_cmd;

    logic                         r_out_valid;
    logic                         n_out_valid;
    ktpr_pkg::t_status            r_status;
    ktpr_pkg::t_status            n_status;
    logic [ktpr_pkg::SCORE_W-1:0] r_score_out;
    logic [ktpr_pkg::SCORE_W-1:0] n_score_out;
    logic [ktpr_pkg::SLOT_W-1:0]  r_slot_idx;
    logic [ktpr_pkg::SLOT_W-1:0]  n_slot_idx;

    logic                         w_accept;
    logic                         w_exec;
    logic                         w_any_hit;
    logic [ktpr_pkg::ENTRIES-1:0] w_wr;
    ktpr_pkg::t_chain             w_chain [0:ktpr_pkg::ENTRIES];

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ktpr_pkg::ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // Active count saturates at the table size
    always_comb begin
        if (32'(r_cfg) > 32'(ktpr_pkg::ENTRIES)) begin
            w_act_cnt = ktpr_pkg::CNT_W'(ktpr_pkg::ENTRIES);
        end else begin
            w_act_cnt = ktpr_pkg::CNT_W'(r_cfg);
        end
    end

    // Handshake: execute when the output register is free
    assign w_exec      = r_busy && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_busy || w_exec;
    assign w_accept    = i_in.valid && i_in.ready;

    always_comb begin
        n_busy = r_busy;
        if (w_exec) begin
            n_busy = 1'b0;
        end
        if (w_accept) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    // Command register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.exec      <= 1'b1;
            r_cmd.mode      <= i_in.mode;
            r_cmd.key       <= i_in.book_key;
            r_cmd.score     <= i_in.score_in;
            r_cmd.load_slot <= i_in.load_slot;
        end
    end

    always_comb begin
        w_cmd      = r_cmd;
        w_cmd.exec = w_exec;
    end

    // Row of slot cells
    assign w_chain[0] = '0;
    assign w_any_hit  = w_chain[ktpr_pkg::ENTRIES].hit;

    for (genvar g = 0; g < ktpr_pkg::ENTRIES; g++) begin : g_cell
        ktpr_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_id      (ktpr_pkg::IDX_W'(g)),
            .i_act     (32'(g) < 32'(w_act_cnt)),
            .i_cmd     (w_cmd),
            .i_any_hit (w_any_hit),
            .i_chain   (w_chain[g]),
            .o_chain   (w_chain[g+1]),
            .o_wr      (w_wr[g])
        );
    end

    // Result formation
    always_comb begin
        n_status    = ktpr_pkg::ST_MISS;
        n_score_out = '0;
        n_slot_idx  = '0;
        case (r_cmd.mode)
            ktpr_pkg::MODE_LOOKUP: begin
                if (w_any_hit) begin
                    n_status    = ktpr_pkg::ST_HIT;
                    n_score_out = w_chain[ktpr_pkg::ENTRIES].hit_score;
                    n_slot_idx  = ktpr_pkg::SLOT_W'(w_chain[ktpr_pkg::ENTRIES].hit_idx);
                end
            end
            ktpr_pkg::MODE_ADD: begin
                if (w_any_hit) begin
                    n_status   = ktpr_pkg::ST_UPDATED;
                    n_slot_idx = ktpr_pkg::SLOT_W'(w_chain[ktpr_pkg::ENTRIES].hit_idx);
                end else if (w_chain[ktpr_pkg::ENTRIES].cand) begin
                    n_status   = ktpr_pkg::ST_REPLACED;
                    n_slot_idx = ktpr_pkg::SLOT_W'(w_chain[ktpr_pkg::ENTRIES].cand_idx);
                end else begin
                    n_status   = ktpr_pkg::ST_DROPPED;
                end
            end
            ktpr_pkg::MODE_LOAD: begin
                if (32'(r_cmd.load_slot) < 32'(ktpr_pkg::ENTRIES)) begin
                    n_status   = ktpr_pkg::ST_LOADED;
                    n_slot_idx = r_cmd.load_slot;
                end else begin
                    n_status   = ktpr_pkg::ST_DROPPED;
                end
            end
            default: begin
                n_status = ktpr_pkg::ST_MISS;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_exec) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_status    <= n_status;
            r_score_out <= n_score_out;
            r_slot_idx  <= n_slot_idx;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.score_out  = r_score_out;
    assign o_out.slot_index = r_slot_idx;

    // Checks
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_wr))
        else $error("more than one slot written in one cycle");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> r_out_valid)
        else $error("executed operation left no result");

    a_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_exec) |=> r_busy)
        else $error("pending operation lost without executing");

    a_no_write_on_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && (r_cmd.mode != ktpr_pkg::MODE_ADD)
         && (r_cmd.mode != ktpr_pkg::MODE_LOAD)) |-> (w_wr == '0))
        else $error("slot written by an operation that does not write");

endmodule
